[sv/rfpc_pkg.sv]
// Shared types, constants and helpers for the reflection fractal pixel colour block.
`timescale 1ns / 1ps
package rfpc_pkg;

	localparam int MAX_LINES = 16;
	localparam int LINE_W = $clog2(MAX_LINES);
	localparam int LCNT_W = $clog2(MAX_LINES + 1);
	localparam int DIV_STEPS = 32;
	localparam int DCNT_W = $clog2(DIV_STEPS);

	localparam logic [2:0] REG_STEP_X = 3'd0;
	localparam logic [2:0] REG_STEP_Y = 3'd1;
	localparam logic [2:0] REG_OFFSET_X = 3'd2;
	localparam logic [2:0] REG_OFFSET_Y = 3'd3;
	localparam logic [2:0] REG_BAND_SCALE = 3'd4;
	localparam logic [2:0] REG_COLOUR_MODE = 3'd5;
	localparam logic [2:0] REG_PALETTE_SIZE = 3'd6;
	localparam logic [2:0] REG_ACTIVE_LINES = 3'd7;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP_MUL,
		ST_MAP_ADD,
		ST_LN_READ,
		ST_LN_PROD,
		ST_LN_DOT,
		ST_LN_SCALE,
		ST_LN_SUB,
		ST_LN_SQ,
		ST_LN_CMP,
		ST_BAND_MUL,
		ST_BAND_FIN,
		ST_DIV,
		ST_FIN
	} rfpc_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_MAP_MUL,
		OP_MAP_ADD,
		OP_LN_READ,
		OP_LN_PROD,
		OP_LN_DOT,
		OP_LN_SCALE,
		OP_LN_SUB,
		OP_LN_SQ,
		OP_LN_CMP,
		OP_BAND_MUL,
		OP_BAND_FIN,
		OP_DIV_STEP,
		OP_OUT
	} rfpc_op_t;

	typedef struct packed {
		rfpc_op_t op;
		logic [LINE_W-1:0] line;
	} rfpc_cmd_t;

	typedef struct packed {
		logic [LCNT_W-1:0] lines;
	} rfpc_status_t;

	typedef struct packed {
		logic signed [23:0] lx;
		logic signed [23:0] ly;
		logic signed [21:0] nx;
		logic signed [21:0] ny;
	} rfpc_entry_t;

	// Saturate a wide signed value to the Q4.20 coordinate range.
	function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
		logic signed [39:0] hi;
		logic signed [39:0] lo;
		hi = 40'sd8388607;
		lo = -40'sd8388608;
		if (v > hi) begin
			sat24 = 24'sh7FFFFF;
		end else if (v < lo) begin
			sat24 = 24'sh800000;
		end else begin
			sat24 = v[23:0];
		end
	endfunction

endpackage

[sv/rfpc_ctrl.sv]
// Sequencer for the reflection fractal block: steps each word through its phases.
`timescale 1ns / 1ps
module rfpc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic func,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  rfpc_pkg::rfpc_status_t status,
	output rfpc_pkg::rfpc_cmd_t cmd
);

	rfpc_pkg::rfpc_state_t state_q, state_d;
	logic [rfpc_pkg::LCNT_W-1:0] line_q, line_d;
	logic [rfpc_pkg::DCNT_W-1:0] dcnt_q, dcnt_d;
	logic out_valid_q, out_valid_d;
	logic [rfpc_pkg::LCNT_W-1:0] line_nx;

	assign line_nx = line_q + 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfpc_pkg::ST_IDLE;
			line_q <= '0;
			dcnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			line_q <= line_d;
			dcnt_q <= dcnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		line_d = line_q;
		dcnt_d = dcnt_q;
		out_valid_d = out_valid_q && out_stall;
		in_stall = 1'b1;
		cmd.op = rfpc_pkg::OP_NONE;
		cmd.line = line_q[rfpc_pkg::LINE_W-1:0];
		unique case (state_q)
			rfpc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && func == rfpc_pkg::FUNC_PIXEL) begin
					state_d = rfpc_pkg::ST_MAP_MUL;
				end
			end
			rfpc_pkg::ST_MAP_MUL: begin
				cmd.op = rfpc_pkg::OP_MAP_MUL;
				state_d = rfpc_pkg::ST_MAP_ADD;
			end
			rfpc_pkg::ST_MAP_ADD: begin
				cmd.op = rfpc_pkg::OP_MAP_ADD;
				line_d = '0;
				state_d = (status.lines == '0) ? rfpc_pkg::ST_BAND_MUL : rfpc_pkg::ST_LN_READ;
			end
			rfpc_pkg::ST_LN_READ: begin
				cmd.op = rfpc_pkg::OP_LN_READ;
				state_d = rfpc_pkg::ST_LN_PROD;
			end
			rfpc_pkg::ST_LN_PROD: begin
				cmd.op = rfpc_pkg::OP_LN_PROD;
				state_d = rfpc_pkg::ST_LN_DOT;
			end
			rfpc_pkg::ST_LN_DOT: begin
				cmd.op = rfpc_pkg::OP_LN_DOT;
				state_d = rfpc_pkg::ST_LN_SCALE;
			end
			rfpc_pkg::ST_LN_SCALE: begin
				cmd.op = rfpc_pkg::OP_LN_SCALE;
				state_d = rfpc_pkg::ST_LN_SUB;
			end
			rfpc_pkg::ST_LN_SUB: begin
				cmd.op = rfpc_pkg::OP_LN_SUB;
				state_d = rfpc_pkg::ST_LN_SQ;
			end
			rfpc_pkg::ST_LN_SQ: begin
				cmd.op = rfpc_pkg::OP_LN_SQ;
				state_d = rfpc_pkg::ST_LN_CMP;
			end
			rfpc_pkg::ST_LN_CMP: begin
				cmd.op = rfpc_pkg::OP_LN_CMP;
				if (line_nx == status.lines) begin
					state_d = rfpc_pkg::ST_BAND_MUL;
				end else begin
					line_d = line_nx;
					state_d = rfpc_pkg::ST_LN_READ;
				end
			end
			rfpc_pkg::ST_BAND_MUL: begin
				cmd.op = rfpc_pkg::OP_BAND_MUL;
				state_d = rfpc_pkg::ST_BAND_FIN;
			end
			rfpc_pkg::ST_BAND_FIN: begin
				cmd.op = rfpc_pkg::OP_BAND_FIN;
				dcnt_d = '0;
				state_d = rfpc_pkg::ST_DIV;
			end
			rfpc_pkg::ST_DIV: begin
				cmd.op = rfpc_pkg::OP_DIV_STEP;
				dcnt_d = dcnt_q + 1'b1;
				if (dcnt_q == rfpc_pkg::DCNT_W'(rfpc_pkg::DIV_STEPS - 1)) begin
					state_d = rfpc_pkg::ST_FIN;
				end
			end
			rfpc_pkg::ST_FIN: begin
				// The result register may still hold an untaken word.
				if (!out_valid_q || !out_stall) begin
					cmd.op = rfpc_pkg::OP_OUT;
					out_valid_d = 1'b1;
					state_d = rfpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rfpc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[sv/rfpc_dp.sv]
// Datapath: configuration registers, mirror table, reflection arithmetic and modulo unit.
`timescale 1ns / 1ps
module rfpc_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic func,
	input  logic [15:0] pixel_x,
	input  logic [15:0] pixel_y,
	input  logic [3:0] entry_index,
	input  logic signed [23:0] line_origin_x,
	input  logic signed [23:0] line_origin_y,
	input  logic signed [21:0] line_normal_x,
	input  logic signed [21:0] line_normal_y,
	input  logic cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  rfpc_pkg::rfpc_cmd_t cmd,
	output rfpc_pkg::rfpc_status_t status,
	output logic [7:0] colour_index,
	output logic [4:0] reflect_count
);

	logic [20:0] step_x_q, step_y_q;
	logic signed [23:0] offset_x_q, offset_y_q;
	logic [31:0] band_scale_q;
	logic colour_mode_q;
	logic [8:0] palette_size_q;
	logic [4:0] active_lines_q;

	rfpc_pkg::rfpc_entry_t mem [rfpc_pkg::MAX_LINES];
	rfpc_pkg::rfpc_entry_t ent_q;

	logic [15:0] pix_x_q, pix_y_q;
	logic [36:0] mpx_q, mpy_q;
	logic signed [23:0] x_q, y_q;
	logic signed [46:0] px_q, py_q;
	logic [46:0] x2_q, y2_q;
	logic signed [28:0] h_q;
	logic [47:0] dold_q;
	logic signed [50:0] hx_q, hy_q;
	logic signed [23:0] cx_q, cy_q;
	logic [46:0] cx2_q, cy2_q;
	logic [4:0] count_q;
	logic [55:0] bprod_q;
	logic ysign_q;
	logic [31:0] dvd_q;
	logic [8:0] rem_q;
	logic [7:0] colour_q;
	logic [4:0] rcount_q;

	logic signed [24:0] dx, dy;
	logic signed [47:0] dot;
	logic signed [47:0] sq_x, sq_y, sq_cx, sq_cy;
	logic signed [39:0] map_x, map_y, sub_x, sub_y;
	logic [47:0] dnew;
	logic [23:0] ymag;
	logic [19:0] bq;
	logic [31:0] bval;
	logic [8:0] divisor;
	logic [9:0] trial;

	assign status.lines = (active_lines_q > 5'(rfpc_pkg::MAX_LINES))
		? rfpc_pkg::LCNT_W'(rfpc_pkg::MAX_LINES) : rfpc_pkg::LCNT_W'(active_lines_q);
	assign divisor = (palette_size_q > 9'd256) ? 9'd256 : palette_size_q;

	assign dx = {x_q[23], x_q} - {ent_q.lx[23], ent_q.lx};
	assign dy = {y_q[23], y_q} - {ent_q.ly[23], ent_q.ly};
	assign dot = {px_q[46], px_q} + {py_q[46], py_q};
	assign sq_x = x_q * x_q;
	assign sq_y = y_q * y_q;
	assign sq_cx = cx_q * cx_q;
	assign sq_cy = cy_q * cy_q;
	assign map_x = $signed({3'b000, mpx_q}) + {{16{offset_x_q[23]}}, offset_x_q};
	assign map_y = $signed({3'b000, mpy_q}) + {{16{offset_y_q[23]}}, offset_y_q};
	// The correction is the product shifted down by twenty with floor rounding.
	assign sub_x = {{16{x_q[23]}}, x_q} - {{9{hx_q[50]}}, hx_q[50:20]};
	assign sub_y = {{16{y_q[23]}}, y_q} - {{9{hy_q[50]}}, hy_q[50:20]};
	assign dnew = {1'b0, cx2_q} + {1'b0, cy2_q};
	assign ymag = y_q[23] ? 24'(-y_q) : y_q;
	assign bq = bprod_q[55:36];
	assign bval = ysign_q ? 32'(-{12'd0, bq}) : {12'd0, bq};
	assign trial = {rem_q, dvd_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q <= 21'd4096;
			step_y_q <= 21'd4096;
			offset_x_q <= -24'sd524288;
			offset_y_q <= -24'sd524288;
			band_scale_q <= 32'd16777216;
			colour_mode_q <= 1'b0;
			palette_size_q <= 9'd256;
			active_lines_q <= 5'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rfpc_pkg::REG_STEP_X: step_x_q <= cfg_data[20:0];
				rfpc_pkg::REG_STEP_Y: step_y_q <= cfg_data[20:0];
				rfpc_pkg::REG_OFFSET_X: offset_x_q <= cfg_data[23:0];
				rfpc_pkg::REG_OFFSET_Y: offset_y_q <= cfg_data[23:0];
				rfpc_pkg::REG_BAND_SCALE: band_scale_q <= cfg_data;
				rfpc_pkg::REG_COLOUR_MODE: colour_mode_q <= cfg_data[0];
				rfpc_pkg::REG_PALETTE_SIZE: palette_size_q <= cfg_data[8:0];
				rfpc_pkg::REG_ACTIVE_LINES: active_lines_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Mirror table: one write port for loads, one registered read port.
	always_ff @(posedge clk) begin
		if (accept && func == rfpc_pkg::FUNC_LOAD) begin
			mem[entry_index] <= '{lx: line_origin_x, ly: line_origin_y,
				nx: line_normal_x, ny: line_normal_y};
		end
		if (cmd.op == rfpc_pkg::OP_LN_READ) begin
			ent_q <= mem[cmd.line];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && func == rfpc_pkg::FUNC_PIXEL) begin
			pix_x_q <= pixel_x;
			pix_y_q <= pixel_y;
		end
		unique case (cmd.op)
			rfpc_pkg::OP_MAP_MUL: begin
				mpx_q <= pix_x_q * step_x_q;
				mpy_q <= pix_y_q * step_y_q;
			end
			rfpc_pkg::OP_MAP_ADD: begin
				x_q <= rfpc_pkg::sat24(map_x);
				y_q <= rfpc_pkg::sat24(map_y);
				count_q <= '0;
			end
			rfpc_pkg::OP_LN_PROD: begin
				px_q <= dx * ent_q.nx;
				py_q <= dy * ent_q.ny;
				x2_q <= sq_x[46:0];
				y2_q <= sq_y[46:0];
			end
			rfpc_pkg::OP_LN_DOT: begin
				// Twice the dot product, floored down by twenty bits.
				h_q <= dot[47:19];
				dold_q <= {1'b0, x2_q} + {1'b0, y2_q};
			end
			rfpc_pkg::OP_LN_SCALE: begin
				hx_q <= ent_q.nx * h_q;
				hy_q <= ent_q.ny * h_q;
			end
			rfpc_pkg::OP_LN_SUB: begin
				cx_q <= rfpc_pkg::sat24(sub_x);
				cy_q <= rfpc_pkg::sat24(sub_y);
			end
			rfpc_pkg::OP_LN_SQ: begin
				cx2_q <= sq_cx[46:0];
				cy2_q <= sq_cy[46:0];
			end
			rfpc_pkg::OP_LN_CMP: begin
				if (dnew < dold_q) begin
					x_q <= cx_q;
					y_q <= cy_q;
					count_q <= count_q + 1'b1;
				end
			end
			rfpc_pkg::OP_BAND_MUL: begin
				bprod_q <= ymag * band_scale_q;
				ysign_q <= y_q[23];
			end
			rfpc_pkg::OP_BAND_FIN: begin
				dvd_q <= colour_mode_q ? {27'd0, count_q} : bval;
				rem_q <= '0;
			end
			rfpc_pkg::OP_DIV_STEP: begin
				// Restoring division, one dividend bit per cycle.
				dvd_q <= {dvd_q[30:0], 1'b0};
				if (trial >= {1'b0, divisor}) begin
					rem_q <= 9'(trial - {1'b0, divisor});
				end else begin
					rem_q <= trial[8:0];
				end
			end
			rfpc_pkg::OP_OUT: begin
				colour_q <= (divisor == '0) ? 8'd0 : rem_q[7:0];
				rcount_q <= count_q;
			end
			default: ;
		endcase
	end

	assign colour_index = colour_q;
	assign reflect_count = rcount_q;

endmodule

[sv/reflection_fractal_pixel_colour.sv]
// Top level of the reflection fractal pixel colour block.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall   | func, pixel_x, pixel_y, entry_index, line_*
//  out     | out_valid/out_stall | colour_index, reflect_count
//  cfg     | cfg_write           | cfg_index, cfg_data
//
// A load word is taken straight from idle and the input is ready again at once.
// A pixel word passes from acceptance through the coordinate mapping, then each
// active line in turn through the multipliers, then band scaling and the bit-serial
// modulo unit, and may wait on the output register before its result is written.
// Reset is asynchronous; it clears the sequencer and sets the configuration registers to their defaults;
// the mirror table holds nothing defined until loaded.
// A waiting result holds in the output register while the next word is worked on.
`timescale 1ns / 1ps
module reflection_fractal_pixel_colour (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic func,
	input  logic [15:0] pixel_x,
	input  logic [15:0] pixel_y,
	input  logic [3:0] entry_index,
	input  logic signed [23:0] line_origin_x,
	input  logic signed [23:0] line_origin_y,
	input  logic signed [21:0] line_normal_x,
	input  logic signed [21:0] line_normal_y,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] colour_index,
	output logic [4:0] reflect_count,
	input  logic cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);

	rfpc_pkg::rfpc_cmd_t cmd;
	rfpc_pkg::rfpc_status_t status;
	logic accept;

	assign accept = in_valid && !in_stall;

	rfpc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.func(func),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.cmd(cmd)
	);

	rfpc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.func(func),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.entry_index(entry_index),
		.line_origin_x(line_origin_x),
		.line_origin_y(line_origin_y),
		.line_normal_x(line_normal_x),
		.line_normal_y(line_normal_y),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.status(status),
		.colour_index(colour_index),
		.reflect_count(reflect_count)
	);

`ifndef SYNTHESIS
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func |=> in_stall)
		else $error("input not stalled after a pixel word");
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !func |=> !in_stall)
		else $error("input stalled after a load word");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reflect_count <= 5'd16)
		else $error("reflection count beyond the table depth");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the reflection fractal pixel colour block.
`timescale 1ns / 1ps
module tb_top;

	localparam int SEND_ITEMS = 1450;
	localparam int SETTLE_CYCLES = 200;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [7:0] colour;
		logic [4:0] count;
	} pixel_result_t;

	class colour_scoreboard;
		logic signed [23:0] org_x[rfpc_pkg::MAX_LINES];
		logic signed [23:0] org_y[rfpc_pkg::MAX_LINES];
		logic signed [21:0] nrm_x[rfpc_pkg::MAX_LINES];
		logic signed [21:0] nrm_y[rfpc_pkg::MAX_LINES];
		logic [20:0] step_x, step_y;
		logic signed [23:0] off_x, off_y;
		logic [31:0] band_scale;
		logic depth_mode;
		logic [8:0] palette;
		logic [4:0] lines;
		pixel_result_t pending_q[$];
		int mismatches;
		int pixels_checked;
		int loads_seen;

		function new();
			step_x = 21'd4096;
			step_y = 21'd4096;
			off_x = -24'sd524288;
			off_y = -24'sd524288;
			band_scale = 32'd16777216;
			depth_mode = 1'b0;
			palette = 9'd256;
			lines = 5'd0;
			mismatches = 0;
			pixels_checked = 0;
			loads_seen = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				rfpc_pkg::REG_STEP_X: step_x = val[20:0];
				rfpc_pkg::REG_STEP_Y: step_y = val[20:0];
				rfpc_pkg::REG_OFFSET_X: off_x = val[23:0];
				rfpc_pkg::REG_OFFSET_Y: off_y = val[23:0];
				rfpc_pkg::REG_BAND_SCALE: band_scale = val;
				rfpc_pkg::REG_COLOUR_MODE: depth_mode = val[0];
				rfpc_pkg::REG_PALETTE_SIZE: palette = val[8:0];
				default: lines = val[4:0];
			endcase
		endfunction

		function longint clamp_q420(longint v);
			if (v > 64'sd8388607) return 64'sd8388607;
			if (v < -64'sd8388608) return -64'sd8388608;
			return v;
		endfunction

		// Works out the colour of one pixel word, or records a mirror load.
		function void note_word(logic f, logic [15:0] px, logic [15:0] py, logic [3:0] ei,
				logic signed [23:0] lox, logic signed [23:0] loy,
				logic signed [21:0] nx, logic signed [21:0] ny);
			longint x, y, dot, h, cx, cy, p, q, nxl, nyl;
			logic [63:0] qbits;
			logic [31:0] v, dv;
			int n;
			pixel_result_t r;
			if (f == rfpc_pkg::FUNC_LOAD) begin
				org_x[ei] = lox;
				org_y[ei] = loy;
				nrm_x[ei] = nx;
				nrm_y[ei] = ny;
				loads_seen++;
				return;
			end
			x = clamp_q420(longint'(px) * longint'(step_x) + longint'(off_x));
			y = clamp_q420(longint'(py) * longint'(step_y) + longint'(off_y));
			n = (lines > rfpc_pkg::MAX_LINES) ? rfpc_pkg::MAX_LINES : int'(lines);
			r.count = 0;
			for (int i = 0; i < n; i++) begin
				nxl = longint'(nrm_x[i]);
				nyl = longint'(nrm_y[i]);
				dot = (x - longint'(org_x[i])) * nxl + (y - longint'(org_y[i])) * nyl;
				h = (dot * 2) >>> 20;
				cx = clamp_q420(x - ((nxl * h) >>> 20));
				cy = clamp_q420(y - ((nyl * h) >>> 20));
				if (cx * cx + cy * cy < x * x + y * y) begin
					x = cx;
					y = cy;
					r.count++;
				end
			end
			if (depth_mode) begin
				v = 32'(r.count);
			end else begin
				p = y * longint'(band_scale);
				// The band value truncates toward zero, not toward minus infinity.
				if (p < 0) q = -((-p) >>> 36);
				else q = p >>> 36;
				qbits = q;
				v = qbits[31:0];
			end
			dv = (palette > 9'd256) ? 32'd256 : 32'(palette);
			r.colour = (dv == 0) ? 8'd0 : 8'(v % dv);
			pending_q.insert(pending_q.size(), r);
		endfunction

		function void check_result(logic [7:0] colour, logic [4:0] count);
			pixel_result_t e;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result colour %0d count %0d", colour, count);
				return;
			end
			e = pending_q.pop_front();
			pixels_checked++;
			if (colour !== e.colour || count !== e.count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: pixel %0d expected colour %0d count %0d, got %0d %0d",
						pixels_checked, e.colour, e.count, colour, count);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic func;
	logic [15:0] pixel_x, pixel_y;
	logic [3:0] entry_index;
	logic signed [23:0] line_origin_x, line_origin_y;
	logic signed [21:0] line_normal_x, line_normal_y;
	logic out_valid;
	logic out_stall;
	logic [7:0] colour_index;
	logic [4:0] reflect_count;
	logic cfg_write;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	colour_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	longint cycles;

	reflection_fractal_pixel_colour DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .pixel_x(pixel_x), .pixel_y(pixel_y), .entry_index(entry_index),
		.line_origin_x(line_origin_x), .line_origin_y(line_origin_y),
		.line_normal_x(line_normal_x), .line_normal_y(line_normal_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.colour_index(colour_index), .reflect_count(reflect_count),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: check each accepted word, then pick the next stall at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(colour_index, reflect_count);
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send_word(logic f, logic [15:0] px, logic [15:0] py, logic [3:0] ei,
			logic signed [23:0] lox, logic signed [23:0] loy,
			logic signed [21:0] nx, logic signed [21:0] ny);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		pixel_x <= px;
		pixel_y <= py;
		entry_index <= ei;
		line_origin_x <= lox;
		line_origin_y <= loy;
		line_normal_x <= nx;
		line_normal_y <= ny;
		do @(posedge clk); while (in_stall);
		sb.note_word(f, px, py, ei, lox, loy, nx, ny);
	endtask

	task automatic send_pixel(logic [15:0] px, logic [15:0] py);
		send_word(rfpc_pkg::FUNC_PIXEL, px, py, 4'($urandom), 24'($urandom), 24'($urandom),
			22'($urandom), 22'($urandom));
	endtask

	task automatic send_load(logic [3:0] ei, logic signed [23:0] lox, logic signed [23:0] loy,
			logic signed [21:0] nx, logic signed [21:0] ny);
		send_word(rfpc_pkg::FUNC_LOAD, 16'($urandom), 16'($urandom), ei, lox, loy, nx, ny);
	endtask

	// A mirror with a unit normal along one of eight directions, or else a random normal.
	task automatic send_random_load(logic [3:0] ei);
		logic signed [21:0] nx, ny;
		int dir;
		dir = $urandom_range(9);
		case (dir)
			0: begin nx = 22'sd1048576; ny = 22'sd0; end
			1: begin nx = -22'sd1048576; ny = 22'sd0; end
			2: begin nx = 22'sd0; ny = 22'sd1048576; end
			3: begin nx = 22'sd0; ny = -22'sd1048576; end
			4: begin nx = 22'sd741455; ny = 22'sd741455; end
			5: begin nx = -22'sd741455; ny = 22'sd741455; end
			6: begin nx = 22'sd741455; ny = -22'sd741455; end
			7: begin nx = -22'sd741455; ny = -22'sd741455; end
			default: begin nx = 22'($urandom); ny = 22'($urandom); end
		endcase
		if ($urandom_range(3) == 0)
			send_load(ei, 24'($urandom), 24'($urandom), nx, ny);
		else
			send_load(ei, 24'($signed(20'($urandom))), 24'($signed(20'($urandom))), nx, ny);
	endtask

	task automatic cfg_put(logic [2:0] idx, logic [31:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// Registers change only once every pending pixel has come out and the block has settled.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [20:0] sx, logic [20:0] sy, logic [23:0] ox,
			logic [23:0] oy, logic [31:0] bs, logic mode, logic [8:0] pal, logic [4:0] act);
		wait_idle();
		cfg_put(rfpc_pkg::REG_STEP_X, 32'(sx));
		cfg_put(rfpc_pkg::REG_STEP_Y, 32'(sy));
		cfg_put(rfpc_pkg::REG_OFFSET_X, 32'(ox));
		cfg_put(rfpc_pkg::REG_OFFSET_Y, 32'(oy));
		cfg_put(rfpc_pkg::REG_BAND_SCALE, bs);
		cfg_put(rfpc_pkg::REG_COLOUR_MODE, 32'(mode));
		cfg_put(rfpc_pkg::REG_PALETTE_SIZE, 32'(pal));
		cfg_put(rfpc_pkg::REG_ACTIVE_LINES, 32'(act));
		cfg_write <= 1'b0;
	endtask

	task automatic random_config();
		logic [8:0] pal;
		logic [4:0] act;
		logic [20:0] sx, sy;
		case ($urandom_range(5))
			0: pal = 9'd0;
			1: pal = 9'd1;
			2: pal = 9'd256;
			3: pal = 9'($urandom_range(257, 511));
			default: pal = 9'($urandom_range(2, 255));
		endcase
		case ($urandom_range(4))
			0: act = 5'd16;
			1: act = 5'($urandom_range(17, 31));
			default: act = 5'($urandom_range(16));
		endcase
		sx = ($urandom_range(4) == 0) ? 21'($urandom) : 21'($urandom_range(256, 16384));
		sy = ($urandom_range(4) == 0) ? 21'($urandom) : 21'($urandom_range(256, 16384));
		configure(sx, sy, ($urandom_range(3) == 0) ? 24'($urandom) : 24'(-$urandom_range(2097152)),
			($urandom_range(3) == 0) ? 24'($urandom) : 24'(-$urandom_range(2097152)),
			($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 28),
			1'($urandom), pal, act);
	endtask

	initial begin
		int sent;
		logic [15:0] px, py;
		sb = new();
		cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= rfpc_pkg::FUNC_LOAD;
		pixel_x <= '0;
		pixel_y <= '0;
		entry_index <= '0;
		line_origin_x <= '0;
		line_origin_y <= '0;
		line_normal_x <= '0;
		line_normal_y <= '0;
		out_stall <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= rfpc_pkg::REG_STEP_X;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings with no lines, extreme pixels driving the coordinates into saturation.
		send_pixel(16'd0, 16'd0);
		send_pixel(16'hFFFF, 16'hFFFF);
		send_pixel(16'd128, 16'd200);
		// Fill the whole table so that no pixel ever reads an unwritten mirror.
		send_load(4'd0, 24'sh7FFFFF, 24'sh800000, 22'sd1048576, 22'sd0);
		send_load(4'd1, 24'sh800000, 24'sh7FFFFF, -22'sd1048576, 22'sd0);
		send_load(4'd2, 24'sd0, 24'sd262144, 22'sd0, 22'sd1048576);
		send_load(4'd3, 24'sd0, -24'sd262144, 22'sd0, -22'sd1048576);
		send_load(4'd4, 24'sd100000, 24'sd0, 22'sh1FFFFF, 22'sh200000);
		for (int i = 5; i < rfpc_pkg::MAX_LINES; i++) send_random_load(4'(i));
		configure(21'h1FFFFF, 21'd1048576, 24'sh7FFFFF, 24'sh800000, 32'hFFFFFFFF, 1'b1,
			9'd0, 5'd31);
		send_pixel(16'd0, 16'd0);
		send_pixel(16'hFFFF, 16'd1);
		configure(21'd0, 21'd0, 24'sd0, 24'sd0, 32'd0, 1'b0, 9'd511, 5'd16);
		send_pixel(16'd5, 16'd5);
		configure(21'd8192, 21'd8192, -24'sd1048576, -24'sd1048576, 32'hFFFFFFFF, 1'b0,
			9'd1, 5'd1);
		send_pixel(16'd64, 16'd17);
		configure(21'd8192, 21'd8192, -24'sd1048576, -24'sd1048576, 32'h01000000, 1'b1,
			9'd7, 5'd16);
		send_pixel(16'd30, 16'd200);
		send_pixel(16'd250, 16'd10);

		sent = 0;
		for (int seg = 0; seg < 6; seg++) begin
			send_idle_pct = (seg < 2) ? 22 : (seg < 4) ? 84 : 0;
			recv_idle_pct = (seg < 2) ? 84 : (seg < 4) ? 22 : 0;
			random_config();
			for (int k = 0; k < (SEND_ITEMS - 25) / 6; k++) begin
				if ($urandom_range(9) < 2) begin
					send_random_load(4'($urandom));
				end else begin
					px = ($urandom_range(9) < 7) ? 16'($urandom_range(511)) : 16'($urandom);
					py = ($urandom_range(9) < 7) ? 16'($urandom_range(511)) : 16'($urandom);
					send_pixel(px, py);
				end
				sent++;
			end
		end

		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Checked %0d pixel words and %0d mirror loads over %0d random words,",
			sb.pixels_checked, sb.loads_seen, sent);
		$display("in band and depth modes across saturating and extreme settings.");
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
